### sv/tpe_pkg.sv
`timescale 1ns / 1ps
// constants, codes and small helpers for the tableau pivot engine
// no dependencies; imported by tableau_pivot_engine_core
package tpe_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 64;

  // Q16.16 entry width, fraction bits and divider dividend width
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int DVD_W  = DATA_W + FRAC_W;
  // width of row and column counters, enough to hold 256
  localparam int CNT_W  = 9;

  localparam logic [30:0] TOL_RESET  = 31'd7;
  localparam logic [5:0]  ROWS_RESET = 6'd32;
  localparam logic [6:0]  COLS_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PIVOT = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ROW_RANGE = 2'd1,
    ST_COL_RANGE = 2'd2,
    ST_SMALL     = 2'd3
  } status_t;

  localparam logic [1:0] REG_TOL  = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;

  // magnitude as unsigned, so the most negative value maps to 2^31
  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] m;
    m = x[DATA_W-1] ? (~x + 1'b1) : x;
    return m;
  endfunction

endpackage

### sv/tableau_pivot_engine_core.sv
`timescale 1ns / 1ps
// tableau pivot engine: Q16.16 tableau store with a Gauss-Jordan pivot sequencer
// depends on tpe_pkg
//
// usage
//   requests enter on start/opcode/row_index/col_index/entry_value and are taken
//   at a clock edge with start high and busy low; busy stays high while a
//   request is being worked on
//   every request yields exactly one result: done is high for one cycle with
//   read_value and status; the receiver cannot stall, so a result is never held
//   configuration (tolerance, rows in use, columns in use) is written through
//   cfg_write/cfg_index/cfg_data, one register per edge; the user must write
//   it only while idle, as the block itself does not enforce this
// result timing
//   write, unknown opcode and index failures: result in the next cycle
//   read: the store read is registered, then S_RDOUT registers the result
//   pivot: each pivot-row entry goes through a 48-step restoring divider, each
//   reduced entry through the single store port pair plus multiply, shift and
//   subtract steps; a row whose factor is within the tolerance is not reduced
// throughput
//   writes back to back; a read holds busy through S_RDOUT, a pivot until done
// reset
//   rst clears control and restores the register defaults; the store is not
//   cleared and entries are undefined until written
module tableau_pivot_engine_core
  import tpe_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [4:0]  row_index,
  input  logic [5:0]  col_index,
  input  logic signed [31:0] entry_value,
  output logic        done,
  output logic signed [31:0] read_value,
  output logic [1:0]  status,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  // sequencer states, one-hot
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RDOUT = 12'b000000000010,
    S_PCHK  = 12'b000000000100,
    S_DLOAD = 12'b000000001000,
    S_DIV   = 12'b000000010000,
    S_DWR   = 12'b000000100000,
    S_RNEXT = 12'b000001000000,
    S_FCHK  = 12'b000010000000,
    S_PV    = 12'b000100000000,
    S_MUL   = 12'b001000000000,
    S_SHF   = 12'b010000000000,
    S_SUB   = 12'b100000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [30:0] tol;
  logic [5:0]  row_count;
  logic [6:0]  col_count;

  // tableau store
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  // pivot bookkeeping
  logic [CNT_W-1:0]  pr, pc, r_cnt, c_cnt;
  logic [DATA_W-1:0] piv, f_val, pv_val, v_val;

  // divider
  logic [DATA_W-1:0] dsr, rem;
  logic [DVD_W-1:0]  dvd;
  logic [5:0]        dcnt;
  logic              qneg;
  logic [DATA_W:0]   rem_sh;
  logic              ge;
  logic [DATA_W-1:0] q_sat;

  // multiply, shift, subtract
  logic signed [63:0] prod_full;
  logic signed [63:0] prod_adj;
  logic signed [DVD_W-1:0] prod_s;
  logic signed [DVD_W:0]   diff;
  logic [DATA_W-1:0]       u_sat, u_fin;

  logic [CNT_W-1:0] rows_use, cols_use, row_in, col_in, c_inc;
  logic             accept;

  function automatic logic [AW-1:0] addr_of(input logic [CNT_W-1:0] r,
                                            input logic [CNT_W-1:0] c);
    int a;
    a = int'(r) * MAX_COLS + int'(c);
    return AW'(a);
  endfunction

  // sizes in use, clamped to [1, MAX]
  always_comb begin
    if (row_count == 6'd0) rows_use = CNT_W'(1);
    else if (int'(row_count) > MAX_ROWS) rows_use = CNT_W'(MAX_ROWS);
    else rows_use = CNT_W'(row_count);
    if (col_count == 7'd0) cols_use = CNT_W'(1);
    else if (int'(col_count) > MAX_COLS) cols_use = CNT_W'(MAX_COLS);
    else cols_use = CNT_W'(col_count);
  end

  assign row_in = CNT_W'(row_index);
  assign col_in = CNT_W'(col_index);
  assign c_inc  = c_cnt + 1'b1;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // store read address per state
  always_comb begin
    case (state)
      S_IDLE:  rd_addr = addr_of(row_in, col_in);
      S_PCHK:  rd_addr = addr_of(pr, '0);
      S_DWR:   rd_addr = addr_of(pr, c_inc);
      S_RNEXT: rd_addr = addr_of(r_cnt, pc);
      S_FCHK:  rd_addr = addr_of(pr, '0);
      S_PV:    rd_addr = addr_of(r_cnt, c_cnt);
      S_SUB:   rd_addr = addr_of(pr, c_inc);
      default: rd_addr = addr_of(row_in, col_in);
    endcase
  end

  // divider step
  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dsr});

  // saturate the divider quotient
  always_comb begin
    if (qneg) begin
      if (dvd > DVD_W'(48'h80000000)) q_sat = 32'h80000000;
      else q_sat = DATA_W'(~dvd + 1'b1);
    end else begin
      if (dvd > DVD_W'(48'h7FFFFFFF)) q_sat = 32'h7FFFFFFF;
      else q_sat = dvd[DATA_W-1:0];
    end
  end

  // truncate toward zero, then subtract, saturate and snap
  always_comb begin
    prod_adj = prod_full + (prod_full[63] ? 64'sd65535 : 64'sd0);
    diff = {{(DVD_W-DATA_W+1){v_val[DATA_W-1]}}, v_val} - {prod_s[DVD_W-1], prod_s};
    if (diff > (DVD_W+1)'(49'sh7FFFFFFF)) u_sat = 32'h7FFFFFFF;
    else if (diff < -(DVD_W+1)'(49'sh80000000)) u_sat = 32'h80000000;
    else u_sat = diff[DATA_W-1:0];
    u_fin = (mag32(u_sat) <= {1'b0, tol}) ? '0 : u_sat;
  end

  // store port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tol       <= TOL_RESET;
      row_count <= ROWS_RESET;
      col_count <= COLS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TOL:  tol       <= cfg_data;
        REG_ROWS: row_count <= cfg_data[5:0];
        REG_COLS: col_count <= cfg_data[6:0];
        default:  ;
      endcase
    end
  end

  // store write port per state
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_of(row_in, col_in);
    wr_data = entry_value;
    case (state)
      S_IDLE: begin
        wr_en = accept && (opcode == OP_WRITE) && (row_in < rows_use)
                && (col_in < cols_use);
      end
      S_DWR: begin
        wr_en   = 1'b1;
        wr_addr = addr_of(pr, c_cnt);
        wr_data = q_sat;
      end
      S_FCHK: begin
        wr_en   = (mag32(rdata) <= {1'b0, tol});
        wr_addr = addr_of(r_cnt, pc);
        wr_data = '0;
      end
      S_SUB: begin
        wr_en   = 1'b1;
        wr_addr = addr_of(r_cnt, c_cnt);
        wr_data = u_fin;
      end
      default: ;
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            read_value <= '0;
            status     <= ST_OK;
            pr         <= row_in;
            pc         <= col_in;
            if (opcode == OP_NONE) begin
              done <= 1'b1;
            end else if (row_in >= rows_use) begin
              status <= ST_ROW_RANGE;
              done   <= 1'b1;
            end else if (col_in >= cols_use) begin
              status <= ST_COL_RANGE;
              done   <= 1'b1;
            end else if (opcode == OP_WRITE) begin
              done <= 1'b1;
            end else if (opcode == OP_READ) begin
              state <= S_RDOUT;
            end else begin
              state <= S_PCHK;
            end
          end
        end
        S_RDOUT: begin
          read_value <= rdata;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        S_PCHK: begin
          // pivot entry too small fails the request
          piv <= rdata;
          dsr <= mag32(rdata);
          if (mag32(rdata) <= {1'b0, tol}) begin
            status <= ST_SMALL;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            c_cnt <= '0;
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          rem   <= '0;
          dvd   <= {mag32(rdata), {FRAC_W{1'b0}}};
          qneg  <= rdata[DATA_W-1] ^ piv[DATA_W-1];
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= ge ? DATA_W'(rem_sh - {1'b0, dsr}) : rem_sh[DATA_W-1:0];
          dvd  <= {dvd[DVD_W-2:0], ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'(DVD_W - 1)) state <= S_DWR;
        end
        S_DWR: begin
          c_cnt <= c_inc;
          if (c_inc == cols_use) begin
            r_cnt <= '0;
            state <= S_RNEXT;
          end else begin
            state <= S_DLOAD;
          end
        end
        S_RNEXT: begin
          if (r_cnt == rows_use) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (r_cnt == pr) begin
            r_cnt <= r_cnt + 1'b1;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          f_val <= rdata;
          c_cnt <= '0;
          if (mag32(rdata) <= {1'b0, tol}) begin
            r_cnt <= r_cnt + 1'b1;
            state <= S_RNEXT;
          end else begin
            state <= S_PV;
          end
        end
        S_PV: begin
          pv_val <= rdata;
          state  <= S_MUL;
        end
        S_MUL: begin
          v_val     <= rdata;
          prod_full <= $signed(f_val) * $signed(pv_val);
          state     <= S_SHF;
        end
        S_SHF: begin
          prod_s <= prod_adj[63:FRAC_W];
          state  <= S_SUB;
        end
        S_SUB: begin
          c_cnt <= c_inc;
          if (c_inc == cols_use) begin
            r_cnt <= r_cnt + 1'b1;
            state <= S_RNEXT;
          end else begin
            state <= S_PV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result only appears once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  // a failed pivot never returns data
  a_small_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_SMALL) |-> (read_value == '0))
    else $error("pivot failure with data");

  // the divider never runs past its last step
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dcnt <= 6'(DVD_W - 1))) else $error("divider overrun");

  // the pivot row is never reduced against itself
  a_no_self: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB) |-> (r_cnt != pr)) else $error("pivot row reduced");

  // reduction only follows the multiply and shift steps
  a_sub_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB) |-> ($past(state) == S_SHF)) else $error("step order");

endmodule
